/* design/imusf_pkg.sv */
// shared types and constants of the imu seven-channel smoothing filter
// no dependencies; imported by the lane, merge and top-level modules
`default_nettype none

package imusf_pkg;

   // field widths
   localparam int ACCEL_W = 16;
   localparam int GYRO_W  = 32;
   localparam int TEMP_W  = 16;
   localparam int SHIFT_W = 5;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // reset values of the shift registers
   localparam logic [SHIFT_W-1:0] MOTION_SHIFT_RESET      = 5'd2;
   localparam logic [SHIFT_W-1:0] TEMPERATURE_SHIFT_RESET = 5'd3;

   // register word index, taken from the byte address
   typedef enum logic {
      REG_MOTION_SHIFT      = 1'b0,
      REG_TEMPERATURE_SHIFT = 1'b1
   } csr_reg_type;

   // one smoothed sample, handed from the lanes to the output stage
   typedef struct packed {
      logic signed [ACCEL_W-1:0] accel_x;
      logic signed [ACCEL_W-1:0] accel_y;
      logic signed [ACCEL_W-1:0] accel_z;
      logic signed [GYRO_W-1:0]  gyro_x;
      logic signed [GYRO_W-1:0]  gyro_y;
      logic signed [GYRO_W-1:0]  gyro_z;
      logic signed [TEMP_W-1:0]  temp;
   } sample_result_type;

endpackage

`default_nettype wire

/* design/imusf_lane.sv */
// one smoothing lane: per-channel state and the combinational update
// depends on imusf_pkg for the shift width
`default_nettype none

module imusf_lane #(
   parameter int W = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                enable,
   input  wire                                restart,
   input  wire  [imusf_pkg::SHIFT_W-1:0]      shift,
   input  wire  signed [W-1:0]                sample_in,
   output logic signed [W-1:0]                value_out
);
   import imusf_pkg::*;

   localparam int DW = W + 2;

   logic signed [W-1:0]  value_ff;
   logic                 primed_ff;
   logic signed [W-1:0]  value_in;
   logic signed [DW-1:0] delta;
   logic signed [DW-1:0] half;
   logic signed [DW-1:0] bias;
   logic signed [DW-1:0] sum;
   logic signed [DW-1:0] quot;

   // delta divided by 2**shift, rounded to nearest with ties away from zero; zero for shifts above W+1
   always_comb begin
      delta = DW'(sample_in) - DW'(value_ff);
      half  = {{(DW-1){1'b0}}, 1'b1} << (shift - SHIFT_W'(1));
      if (shift == '0) begin
         bias = '0;
      end else if (delta < 0) begin
         bias = half - DW'(1);
      end else begin
         bias = half;
      end
      sum = delta + bias;
      if (int'(shift) > W + 1) begin
         quot = '0;
      end else begin
         quot = sum >>> shift;
      end
   end

   // first sample after reset or restart passes through
   always_comb begin
      if (!primed_ff || restart) begin
         value_in = sample_in;
      end else begin
         value_in = value_ff + quot[W-1:0];
      end
   end

   assign value_out = value_in;

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else if (enable) begin
         primed_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
      end
   end

   // priming stores the raw sample
   a_prime_passes: assert property (@(posedge clock) disable iff (reset)
      enable && (restart || !primed_ff) |=> primed_ff && value_ff == $past(sample_in))
      else $error("lane did not prime from the raw sample");

   // zero shift follows the input exactly
   a_zero_shift: assert property (@(posedge clock) disable iff (reset)
      enable && shift == '0 |=> value_ff == $past(sample_in))
      else $error("lane with zero shift did not follow its input");

endmodule

`default_nettype wire

/* design/imusf_merge.sv */
// output stage: gathers the seven lane results into a register with a skid entry
// depends on imusf_pkg for the result struct
`default_nettype none

module imusf_merge (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           in_fire,
   input  imusf_pkg::sample_result_type  in_result,
   output logic                          in_stall,
   output logic                          out_valid,
   input  wire                           out_stall,
   output imusf_pkg::sample_result_type  out_result
);
   import imusf_pkg::*;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   sample_result_type out_data_ff;
   sample_result_type out_data_in;
   sample_result_type skid_data_ff;
   sample_result_type skid_data_in;
   logic              out_fire;

   assign out_fire   = out_valid_ff && !out_stall;
   assign in_stall   = skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_result = out_data_ff;

   // output register and skid entry steering
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!out_valid_ff || out_fire) begin
            out_data_in  = in_result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_result;
            skid_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a transfer into an empty stage shows at the output next cycle
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      in_fire && !out_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("transfer into empty stage lost");

   // draining the skid entry frees the input side
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_fire |=> !skid_valid_ff && out_valid_ff)
      else $error("skid entry not drained");

endmodule

`default_nettype wire

/* design/imu_seven_channel_smoothing_filter_top.sv */
// Seven-channel IMU smoothing filter. Each transfer on the req_ channel is one
// sample (accel x/y/z, gyro x/y/z, temperature); each channel runs its own
// first-order smoothing lane and all seven lanes update in the same cycle. The
// block takes one sample per clock while req_stall is low: each lane's
// subtract, round, shift and add is combinational ahead of its state register,
// so its state is ready for the next sample. Results reach rsp_ through an output
// register backed by one skid entry; req_stall rises only when both are full.
// The first sample after reset, or a sample with restart set, passes through
// and primes every channel. Shifts are set through the csr_ port at byte
// address 0 (motion_shift) and 4 (temperature_shift); write them while idle.
// depends on imusf_pkg, imusf_lane and imusf_merge
`default_nettype none

module imu_seven_channel_smoothing_filter_top (
   input  wire                                   clock,
   input  wire                                   reset,
   // sample input channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [imusf_pkg::ACCEL_W-1:0]  req_accel_x_in,
   input  wire  signed [imusf_pkg::ACCEL_W-1:0]  req_accel_y_in,
   input  wire  signed [imusf_pkg::ACCEL_W-1:0]  req_accel_z_in,
   input  wire  signed [imusf_pkg::GYRO_W-1:0]   req_gyro_x_in,
   input  wire  signed [imusf_pkg::GYRO_W-1:0]   req_gyro_y_in,
   input  wire  signed [imusf_pkg::GYRO_W-1:0]   req_gyro_z_in,
   input  wire  signed [imusf_pkg::TEMP_W-1:0]   req_temp_in,
   input  wire                                   req_restart,
   // result channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [imusf_pkg::ACCEL_W-1:0]  rsp_accel_x_out,
   output logic signed [imusf_pkg::ACCEL_W-1:0]  rsp_accel_y_out,
   output logic signed [imusf_pkg::ACCEL_W-1:0]  rsp_accel_z_out,
   output logic signed [imusf_pkg::GYRO_W-1:0]   rsp_gyro_x_out,
   output logic signed [imusf_pkg::GYRO_W-1:0]   rsp_gyro_y_out,
   output logic signed [imusf_pkg::GYRO_W-1:0]   rsp_gyro_z_out,
   output logic signed [imusf_pkg::TEMP_W-1:0]   rsp_temp_out,
   // configuration port
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [imusf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [imusf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [imusf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);
   import imusf_pkg::*;

   logic [SHIFT_W-1:0] motion_shift_ff;
   logic [SHIFT_W-1:0] temperature_shift_ff;
   logic               csr_write;
   csr_reg_type        csr_reg;
   logic               in_fire;
   sample_result_type  lane_result;
   sample_result_type  out_result;

   // configuration registers, decoded by word address
   assign csr_pready = 1'b1;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_shift_ff      <= MOTION_SHIFT_RESET;
         temperature_shift_ff <= TEMPERATURE_SHIFT_RESET;
      end else if (csr_write) begin
         case (csr_reg)
            REG_MOTION_SHIFT:      motion_shift_ff      <= csr_pwdata[SHIFT_W-1:0];
            REG_TEMPERATURE_SHIFT: temperature_shift_ff <= csr_pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_reg)
         REG_MOTION_SHIFT:      csr_prdata = CSR_DATA_W'(motion_shift_ff);
         REG_TEMPERATURE_SHIFT: csr_prdata = CSR_DATA_W'(temperature_shift_ff);
         default:               csr_prdata = '0;
      endcase
   end

   assign in_fire = req_valid && !req_stall;

   // one lane per channel
   imusf_lane #(.W(ACCEL_W)) u_lane_accel_x (
      .clock(clock), .reset(reset), .enable(in_fire), .restart(req_restart),
      .shift(motion_shift_ff), .sample_in(req_accel_x_in),
      .value_out(lane_result.accel_x)
   );

   imusf_lane #(.W(ACCEL_W)) u_lane_accel_y (
      .clock(clock), .reset(reset), .enable(in_fire), .restart(req_restart),
      .shift(motion_shift_ff), .sample_in(req_accel_y_in),
      .value_out(lane_result.accel_y)
   );

   imusf_lane #(.W(ACCEL_W)) u_lane_accel_z (
      .clock(clock), .reset(reset), .enable(in_fire), .restart(req_restart),
      .shift(motion_shift_ff), .sample_in(req_accel_z_in),
      .value_out(lane_result.accel_z)
   );

   imusf_lane #(.W(GYRO_W)) u_lane_gyro_x (
      .clock(clock), .reset(reset), .enable(in_fire), .restart(req_restart),
      .shift(motion_shift_ff), .sample_in(req_gyro_x_in),
      .value_out(lane_result.gyro_x)
   );

   imusf_lane #(.W(GYRO_W)) u_lane_gyro_y (
      .clock(clock), .reset(reset), .enable(in_fire), .restart(req_restart),
      .shift(motion_shift_ff), .sample_in(req_gyro_y_in),
      .value_out(lane_result.gyro_y)
   );

   imusf_lane #(.W(GYRO_W)) u_lane_gyro_z (
      .clock(clock), .reset(reset), .enable(in_fire), .restart(req_restart),
      .shift(motion_shift_ff), .sample_in(req_gyro_z_in),
      .value_out(lane_result.gyro_z)
   );

   imusf_lane #(.W(TEMP_W)) u_lane_temp (
      .clock(clock), .reset(reset), .enable(in_fire), .restart(req_restart),
      .shift(temperature_shift_ff), .sample_in(req_temp_in),
      .value_out(lane_result.temp)
   );

   // output register and skid entry
   imusf_merge u_merge (
      .clock(clock),
      .reset(reset),
      .in_fire(in_fire),
      .in_result(lane_result),
      .in_stall(req_stall),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_result(out_result)
   );

   assign rsp_accel_x_out = out_result.accel_x;
   assign rsp_accel_y_out = out_result.accel_y;
   assign rsp_accel_z_out = out_result.accel_z;
   assign rsp_gyro_x_out  = out_result.gyro_x;
   assign rsp_gyro_y_out  = out_result.gyro_y;
   assign rsp_gyro_z_out  = out_result.gyro_z;
   assign rsp_temp_out    = out_result.temp;

endmodule

`default_nettype wire
